### rtl/assert_macros.svh
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

### rtl/skht_pkg.sv
`timescale 1ns / 1ps
package skht_pkg;
    localparam int unsigned BYTE_W = 7;
    localparam int unsigned AGE_W = 16;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned BC_W = 11;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    // command handed from front to back
    typedef struct packed {
        t_req req;
        logic [AGE_W-1:0] age;
        logic [15:0] hash;
        logic [7:0] len;
    } t_cmd;
endpackage

### rtl/string_keyed_hash_table_top.sv
`timescale 1ns / 1ps
// non-last bytes: dropped, or hashed (multiply, then HASH_W+8 modulo steps) when stored
// last byte: its hash, the hand-over to the back, then a scan of the pool slot by slot,
// a byte-by-byte compare for each candidate, a copy of the name on insert, and the result
// one name in flight; the front stalls until the back has finished with its name
// synchronous active-low reset clears the pool valid bits, count and hash
module string_keyed_hash_table_top #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned NAME_BYTES = 49,
    parameter int unsigned MAX_BUCKETS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic i_valid,
    output logic o_stall,
    input  logic [1:0] i_req_type,
    input  logic [6:0] i_key_byte,
    input  logic i_key_last,
    input  logic [15:0] i_age_in,
    output logic o_valid,
    input  logic i_stall,
    output logic [2:0] o_status,
    output logic [15:0] o_age_out,
    output logic [6:0] o_record_total
);
    localparam int unsigned LEN_W = $clog2(NAME_BYTES + 1);
    localparam int unsigned NIDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int unsigned HASH_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [10:0] r_bucket_count;
    logic w_fstall, w_cv, w_take, w_busy;
    skht_pkg::t_cmd w_cmd;
    logic [NIDX_W-1:0] w_naddr;
    logic [6:0] w_ndata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bucket_count <= 11'd1024;
        else if (i_cfg_we) r_bucket_count <= i_cfg_wdata;
    end

    // the back reads the front's name buffer, so hold new bytes while it works
    assign o_stall = w_fstall || w_busy;

    skht_front #(.NAME_BYTES(NAME_BYTES), .MAX_BUCKETS(MAX_BUCKETS), .LEN_W(LEN_W),
        .NIDX_W(NIDX_W), .HASH_W(HASH_W)) u_front (
        .i_clk, .i_rst_n, .i_bucket_count(r_bucket_count),
        .i_valid(i_valid && !w_busy), .o_stall(w_fstall),
        .i_req_type, .i_key_byte, .i_key_last, .i_age_in,
        .i_nrd_addr(w_naddr), .o_nrd_data(w_ndata),
        .o_cmd_valid(w_cv), .i_cmd_take(w_take), .o_cmd(w_cmd));

    skht_back #(.ENTRIES(ENTRIES), .NAME_BYTES(NAME_BYTES), .LEN_W(LEN_W),
        .NIDX_W(NIDX_W), .HASH_W(HASH_W), .SLOT_W(SLOT_W)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cv), .o_cmd_take(w_take), .i_cmd(w_cmd),
        .o_busy(w_busy), .o_nrd_addr(w_naddr), .i_nrd_data(w_ndata),
        .o_valid, .i_stall, .o_status, .o_age_out, .o_record_total);
endmodule

### rtl/skht_front.sv
`timescale 1ns / 1ps
// collects name bytes, keeps the running hash, emits a command on the last byte
module skht_front #(
    parameter int unsigned NAME_BYTES = 49,
    parameter int unsigned MAX_BUCKETS = 1024,
    parameter int unsigned LEN_W = 6,
    parameter int unsigned NIDX_W = 6,
    parameter int unsigned HASH_W = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [skht_pkg::BC_W-1:0] i_bucket_count,
    input  logic i_valid,
    output logic o_stall,
    input  logic [1:0] i_req_type,
    input  logic [skht_pkg::BYTE_W-1:0] i_key_byte,
    input  logic i_key_last,
    input  logic [skht_pkg::AGE_W-1:0] i_age_in,
    // name buffer read from the back
    input  logic [NIDX_W-1:0] i_nrd_addr,
    output logic [skht_pkg::BYTE_W-1:0] o_nrd_data,
    output logic o_cmd_valid,
    input  logic i_cmd_take,
    output skht_pkg::t_cmd o_cmd
);
    localparam int unsigned PW = HASH_W + skht_pkg::BYTE_W + 1;
    localparam int unsigned CW = $clog2(PW + 1);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_MOD, S_HOLD} t_state;

    t_state r_state;
    logic [skht_pkg::BYTE_W-1:0] r_name [NAME_BYTES];
    logic [LEN_W-1:0] r_len;
    logic [HASH_W-1:0] r_hash;
    logic r_ended;
    logic [skht_pkg::BYTE_W-1:0] r_b;
    logic [PW-1:0] r_prod;
    logic [skht_pkg::BC_W-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic r_last;
    logic [1:0] r_req;
    logic [skht_pkg::AGE_W-1:0] r_age;
    logic r_cmd_valid;
    skht_pkg::t_cmd r_cmd;
    logic [skht_pkg::BC_W-1:0] r_mod_w;
    logic [skht_pkg::BYTE_W-1:0] r_nrd;

    logic [skht_pkg::BC_W-1:0] w_mod;
    logic w_take;
    logic w_store;
    logic [skht_pkg::BC_W:0] w_shift;
    logic [skht_pkg::BC_W:0] w_diff;
    logic [skht_pkg::BC_W-1:0] w_rem;

    always_comb begin
        if (i_bucket_count == '0) w_mod = skht_pkg::BC_W'(1);
        else if (32'(i_bucket_count) > MAX_BUCKETS) w_mod = skht_pkg::BC_W'(MAX_BUCKETS);
        else w_mod = i_bucket_count;
    end

    assign o_stall = (r_state != S_IDLE);
    assign w_take = i_valid && (r_state == S_IDLE);
    assign w_store = (i_key_byte != '0) && !r_ended && (32'(r_len) < NAME_BYTES);
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd = r_cmd;
    assign o_nrd_data = r_nrd;

    // long division, one product bit per cycle, remainder stays below the modulus
    assign w_shift = {r_rem, r_prod[PW-1]};
    assign w_diff = w_shift - {1'b0, r_mod_w};
    assign w_rem = (w_shift >= {1'b0, r_mod_w}) ? skht_pkg::BC_W'(w_diff)
                                                 : skht_pkg::BC_W'(w_shift);

    always_ff @(posedge i_clk) begin
        r_nrd <= r_name[i_nrd_addr];
        if (w_take && w_store) r_name[r_len[NIDX_W-1:0]] <= i_key_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len <= '0;
            r_hash <= '0;
            r_ended <= 1'b0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (r_cmd_valid && i_cmd_take) r_cmd_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_last <= i_key_last;
                        r_req <= i_req_type;
                        r_age <= i_age_in;
                        r_b <= i_key_byte;
                        r_mod_w <= w_mod;
                        if (i_key_byte == '0) r_ended <= 1'b1;
                        if (w_store) begin
                            r_len <= r_len + LEN_W'(1);
                            r_state <= S_MUL;
                        end else begin
                            r_state <= i_key_last ? S_HOLD : S_IDLE;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= (PW'(r_hash) + PW'(r_b)) * PW'(r_b);
                    r_rem <= '0;
                    r_cnt <= CW'(PW);
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_prod <= {r_prod[PW-2:0], 1'b0};
                    r_rem <= w_rem;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_hash <= HASH_W'(w_rem);
                        r_state <= r_last ? S_HOLD : S_IDLE;
                    end
                end
                S_HOLD: begin
                    if (!r_cmd_valid) begin
                        r_cmd_valid <= 1'b1;
                        r_cmd.req <= skht_pkg::t_req'(r_req);
                        r_cmd.age <= r_age;
                        r_cmd.hash <= 16'(r_hash);
                        r_cmd.len <= 8'(r_len);
                        r_len <= '0;
                        r_hash <= '0;
                        r_ended <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/skht_back.sv
`timescale 1ns / 1ps
// walks the pool slot by slot, then byte by byte for a candidate
module skht_back #(
    parameter int unsigned ENTRIES = 64,
    parameter int unsigned NAME_BYTES = 49,
    parameter int unsigned LEN_W = 6,
    parameter int unsigned NIDX_W = 6,
    parameter int unsigned HASH_W = 10,
    parameter int unsigned SLOT_W = 6
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_take,
    input  skht_pkg::t_cmd i_cmd,
    output logic o_busy,
    output logic [NIDX_W-1:0] o_nrd_addr,
    input  logic [skht_pkg::BYTE_W-1:0] i_nrd_data,
    output logic o_valid,
    input  logic i_stall,
    output logic [2:0] o_status,
    output logic [skht_pkg::AGE_W-1:0] o_age_out,
    output logic [skht_pkg::CNT_W-1:0] o_record_total
);
    localparam int unsigned NAW = $clog2(ENTRIES * NAME_BYTES + 1);

    typedef enum logic [3:0] {S_IDLE, S_SCAN, S_TAG, S_RD, S_CMP, S_ACT, S_COPY, S_COPYW,
        S_OUT} t_state;

    t_state r_state;
    logic [ENTRIES-1:0] r_valid;
    logic [HASH_W-1:0] r_bucket [ENTRIES];
    logic [LEN_W-1:0] r_nlen [ENTRIES];
    logic [skht_pkg::AGE_W-1:0] r_sage [ENTRIES];
    logic [skht_pkg::BYTE_W-1:0] r_sname [ENTRIES*NAME_BYTES];
    logic [skht_pkg::BYTE_W-1:0] r_snrd;
    logic [HASH_W-1:0] r_tag_rd;
    logic [LEN_W-1:0] r_len_rd;
    skht_pkg::t_cmd r_cmd;
    logic [SLOT_W:0] r_i;
    logic [LEN_W:0] r_k;
    logic r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic r_free;
    logic [SLOT_W-1:0] r_free_slot;
    logic [skht_pkg::CNT_W-1:0] r_count;
    logic r_ovalid;
    logic [2:0] r_status;
    logic [skht_pkg::AGE_W-1:0] r_age_out;
    logic [NAW-1:0] n_saddr;
    logic w_swr;
    logic [NAW-1:0] w_base;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && !r_ovalid;
    assign o_busy = (r_state != S_IDLE) || i_cmd_valid;
    assign o_nrd_addr = NIDX_W'(r_k);
    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_age_out = r_age_out;
    assign o_record_total = r_count;
    assign w_base = NAW'(r_i[SLOT_W-1:0]) * NAW'(NAME_BYTES);
    assign n_saddr = w_base + NAW'(r_k);
    assign w_swr = (r_state == S_COPYW);

    always_ff @(posedge i_clk) begin
        r_snrd <= r_sname[n_saddr];
        if (w_swr) r_sname[n_saddr] <= i_nrd_data;
    end

    // tag and length of the slot under scan, registered and ready in the next cycle
    always_ff @(posedge i_clk) begin
        r_tag_rd <= r_bucket[r_i[SLOT_W-1:0]];
        r_len_rd <= r_nlen[r_i[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        r_i <= '0;
                        r_k <= '0;
                        r_hit <= 1'b0;
                        r_free <= 1'b0;
                        r_state <= (i_cmd.req == skht_pkg::REQ_NONE) ? S_IDLE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (32'(r_i) == ENTRIES || r_hit) begin
                        r_state <= S_ACT;
                    end else begin
                        logic [SLOT_W-1:0] s;
                        s = r_i[SLOT_W-1:0];
                        if (!r_valid[s] && !r_free) begin
                            r_free <= 1'b1;
                            r_free_slot <= s;
                        end
                        r_state <= S_TAG;
                    end
                end
                S_TAG: begin
                    if (r_valid[r_i[SLOT_W-1:0]] && 16'(r_tag_rd) == r_cmd.hash &&
                        8'(r_len_rd) == r_cmd.len) begin
                        r_k <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_RD: begin
                    if (8'(r_k) == r_cmd.len) begin
                        r_hit <= 1'b1;
                        r_hit_slot <= r_i[SLOT_W-1:0];
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_snrd != i_nrd_data) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_SCAN;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_ACT: begin
                    r_age_out <= '0;
                    r_state <= S_OUT;
                    case (r_cmd.req)
                        skht_pkg::REQ_INSERT: begin
                            if (r_hit) r_status <= skht_pkg::ST_DUPLICATE;
                            else if (!r_free) r_status <= skht_pkg::ST_FULL;
                            else begin
                                r_status <= skht_pkg::ST_INSERTED;
                                r_i <= (SLOT_W+1)'(r_free_slot);
                                r_k <= '0;
                                r_valid[r_free_slot] <= 1'b1;
                                r_bucket[r_free_slot] <= HASH_W'(r_cmd.hash);
                                r_nlen[r_free_slot] <= LEN_W'(r_cmd.len);
                                r_sage[r_free_slot] <= r_cmd.age;
                                r_count <= r_count + 1'b1;
                                r_state <= S_COPY;
                            end
                        end
                        skht_pkg::REQ_SEARCH: begin
                            if (r_hit) begin
                                r_status <= skht_pkg::ST_FOUND;
                                r_age_out <= r_sage[r_hit_slot];
                            end else r_status <= skht_pkg::ST_NOT_FOUND;
                        end
                        default: begin
                            if (r_hit) begin
                                r_status <= skht_pkg::ST_REMOVED;
                                r_valid[r_hit_slot] <= 1'b0;
                                r_count <= r_count - 1'b1;
                            end else r_status <= skht_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
                S_COPY: begin
                    r_state <= (8'(r_k) == r_cmd.len) ? S_OUT : S_COPYW;
                end
                S_COPYW: begin
                    r_k <= r_k + 1'b1;
                    r_state <= S_COPY;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/skht_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module skht_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input logic [2:0] o_status,
    input logic [15:0] o_age_out,
    input logic [6:0] o_record_total
);
    `CHK_IMPLY(a_status_range, i_clk, i_rst_n, o_valid, o_status <= skht_pkg::ST_FULL)
    `CHK_IMPLY(a_age_zero, i_clk, i_rst_n, o_valid && o_status != skht_pkg::ST_FOUND, o_age_out == 16'd0)
    `CHK_IMPLY(a_total_range, i_clk, i_rst_n, o_valid, o_record_total <= 7'd64)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
endmodule

bind string_keyed_hash_table_top skht_checker u_chk (.*);
